// ===== rtl/core/text_terminal_cell_engine_macros.svh =====
// Assertion macros for the text terminal cell engine checker.
// Expects signals named aclk and aresetn in the using scope.
`ifndef TEXT_TERMINAL_CELL_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_CELL_ENGINE_MACROS_SVH

// Clocked check, off while reset is held.
`define TTCE_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define TTCE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/ttce_pkg.sv =====
// Shared constants, types and helpers of the text terminal cell engine.
// No dependencies; used by the parser, the sequencer and the top level.
`default_nettype none

package ttce_pkg;

    // Screen geometry (ROWS 2..16, COLS 2..32)
    localparam int ROWS   = 16;
    localparam int COLS   = 32;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELL_W = 9;   // {bright, symbol}

    localparam int TAB_CELLS = 8;
    localparam int TAB_W     = $clog2(TAB_CELLS + 1);

    typedef logic [ROW_W-1:0]  row_idx_t;
    typedef logic [COL_W-1:0]  col_idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [TAB_W-1:0]  tab_cnt_t;
    typedef logic [3:0]        row_field_t;
    typedef logic [4:0]        col_field_t;

    localparam row_idx_t LAST_ROW = row_idx_t'(ROWS - 1);
    localparam col_idx_t LAST_COL = col_idx_t'(COLS - 1);
    localparam logic [ROW_W:0] ROWS_WIDE = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0] COLS_WIDE = (COL_W + 1)'(COLS);
    localparam tab_cnt_t TAB_COUNT = tab_cnt_t'(TAB_CELLS);

    // Byte codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_HT       = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_CAN      = 8'h18;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_M        = 8'h6D;

    // What the parser asks the sequencer to do with a byte
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_NOP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BS  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LF  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAB = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PUT = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              bright;
    } byte_class_t;

    typedef struct packed {
        logic       cell_written;
        row_field_t cell_row;
        col_field_t cell_col;
        logic [7:0] symbol;
        logic       bright;
        row_field_t cursor_row;
        col_field_t cursor_col;
        logic       scrolled;
        logic       last;
    } result_t;

    // Logical row to physical row of the rotating store
    function automatic row_idx_t phys_row(input row_idx_t lrow, input row_idx_t base);
        logic [ROW_W:0] sum;
        begin
            sum = {1'b0, lrow} + {1'b0, base};
            if (sum >= ROWS_WIDE) begin
                sum = sum - ROWS_WIDE;
            end
            return sum[ROW_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ttce_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none

module ttce_ram #(
    parameter int DATA_W = 9,
    parameter int ADDR_W = 9
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ttce_parser.sv =====
// Escape sequence parser: ESC '[' <param> 'm', holds the current attribute.
// Depends on ttce_pkg.
`default_nettype none

module ttce_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [7:0]           byte_in,
    input  wire logic                 step,     // byte transfer taken
    output ttce_pkg::byte_class_t     cls
);

    localparam logic [1:0] PS_TEXT = 2'd0;
    localparam logic [1:0] PS_ESC  = 2'd1;
    localparam logic [1:0] PS_BRKT = 2'd2;
    localparam logic [1:0] PS_ATTR = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [7:0] param_reg, param_next;
    logic       bright_reg, bright_next;
    logic [ttce_pkg::KIND_W-1:0] kind;

    always_comb begin
        state_next  = state_reg;
        param_next  = param_reg;
        bright_next = bright_reg;
        kind        = ttce_pkg::KIND_NOP;
        case (state_reg)
            PS_ESC: begin
                state_next = (byte_in == ttce_pkg::CH_LBRACKET) ? PS_BRKT : PS_TEXT;
            end
            PS_BRKT: begin
                if (byte_in == ttce_pkg::CH_CAN) begin
                    state_next = PS_TEXT;
                end else begin
                    state_next = PS_ATTR;
                    param_next = byte_in;
                end
            end
            PS_ATTR: begin
                if (byte_in == ttce_pkg::CH_M) begin
                    bright_next = (param_reg == ttce_pkg::CH_ONE);
                end
                state_next = PS_TEXT;
            end
            default: begin
                case (byte_in)
                    ttce_pkg::CH_ESC: state_next = PS_ESC;
                    ttce_pkg::CH_BS:  kind = ttce_pkg::KIND_BS;
                    ttce_pkg::CH_CR:  kind = ttce_pkg::KIND_CR;
                    ttce_pkg::CH_LF:  kind = ttce_pkg::KIND_LF;
                    ttce_pkg::CH_HT:  kind = ttce_pkg::KIND_TAB;
                    default:          kind = ttce_pkg::KIND_PUT;
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= PS_TEXT;
            param_reg  <= 8'h00;
            bright_reg <= 1'b0;
        end else if (step) begin
            state_reg  <= state_next;
            param_reg  <= param_next;
            bright_reg <= bright_next;
        end
    end

    assign cls.kind   = kind;
    assign cls.bright = bright_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ttce_ctrl.sv =====
// Sequencer: cursor, rotating row base, clear sweeps, cell writes and reads.
// Depends on ttce_pkg; drives the cell RAM, takes byte classes from the parser.
`default_nettype none

module ttce_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   s_func,
    input  wire logic [7:0]             s_byte,
    input  wire ttce_pkg::row_field_t   s_row,
    input  wire ttce_pkg::col_field_t   s_col,
    output logic                        step,
    input  wire ttce_pkg::byte_class_t  cls,
    output logic                        ram_we,
    output ttce_pkg::addr_t             ram_waddr,
    output ttce_pkg::cell_t             ram_wdata,
    output ttce_pkg::addr_t             ram_raddr,
    input  wire ttce_pkg::cell_t        ram_rdata,
    output logic                        res_valid,
    output ttce_pkg::result_t           res,
    input  wire logic                   res_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_SCRUB = 3'd5;

    logic [2:0]                  state_reg, state_next;
    ttce_pkg::row_idx_t          row_reg, row_next;
    ttce_pkg::col_idx_t          col_reg, col_next;
    ttce_pkg::row_idx_t          base_reg, base_next;
    ttce_pkg::row_idx_t          scrub_row_reg, scrub_row_next;
    ttce_pkg::addr_t             sweep_reg, sweep_next;
    logic                        scroll_reg, scroll_next;
    ttce_pkg::tab_cnt_t          left_reg, left_next;
    logic [ttce_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [7:0]                  sym_reg, sym_next;
    logic                        bright_reg, bright_next;
    ttce_pkg::row_field_t        rd_row_reg, rd_row_next;
    ttce_pkg::col_field_t        rd_col_reg, rd_col_next;
    logic                        rd_ok_reg, rd_ok_next;
    ttce_pkg::result_t           res_reg, res_next;

    logic accept;
    logic is_write;
    logic rd_ok;
    logic [ttce_pkg::ROW_W:0] nrow;
    logic [ttce_pkg::COL_W:0] ncol;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign step     = accept && !s_func;
    assign is_write = (kind_reg == ttce_pkg::KIND_PUT) || (kind_reg == ttce_pkg::KIND_TAB);
    assign rd_ok    = (int'(s_row) < ttce_pkg::ROWS) && (int'(s_col) < ttce_pkg::COLS);

    // Read port serves only read requests, issued in the transfer cycle
    assign ram_raddr = {ttce_pkg::phys_row(ttce_pkg::row_idx_t'(s_row), base_reg),
                        ttce_pkg::col_idx_t'(s_col)};

    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        scrub_row_next = scrub_row_reg;
        sweep_next     = sweep_reg;
        scroll_next    = scroll_reg;
        left_next      = left_reg;
        kind_next      = kind_reg;
        sym_next       = sym_reg;
        bright_next    = bright_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg;
        ram_wdata      = '0;
        nrow           = {1'b0, row_reg};
        ncol           = {1'b0, col_reg};

        case (state_reg)
            S_CLEAR: begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    if (s_func) begin
                        rd_row_next = s_row;
                        rd_col_next = s_col;
                        rd_ok_next  = rd_ok;
                        state_next  = S_READ;
                    end else begin
                        kind_next   = cls.kind;
                        bright_next = cls.bright;
                        sym_next    = (cls.kind == ttce_pkg::KIND_TAB) ? ttce_pkg::CH_SPACE
                                                                        : s_byte;
                        if (cls.kind == ttce_pkg::KIND_TAB) begin
                            left_next = ttce_pkg::TAB_COUNT;
                        end else if (cls.kind == ttce_pkg::KIND_PUT) begin
                            left_next = ttce_pkg::tab_cnt_t'(1);
                        end else begin
                            left_next = '0;
                        end
                        state_next = S_EXEC;
                    end
                end
            end

            S_READ: begin
                res_next              = '0;
                res_next.cell_row     = rd_row_reg;
                res_next.cell_col     = rd_col_reg;
                res_next.symbol       = rd_ok_reg ? ram_rdata[7:0] : 8'h00;
                res_next.bright       = rd_ok_reg && ram_rdata[8];
                res_next.cursor_row   = ttce_pkg::row_field_t'(row_reg);
                res_next.cursor_col   = ttce_pkg::col_field_t'(col_reg);
                res_next.last         = 1'b1;
                state_next            = S_EMIT;
            end

            S_EXEC: begin
                res_next = '0;
                case (kind_reg)
                    ttce_pkg::KIND_BS: begin
                        if (col_reg != '0) begin
                            ncol = {1'b0, col_reg} - 1'b1;
                        end else if (row_reg != '0) begin
                            nrow = {1'b0, row_reg} - 1'b1;
                            ncol = {1'b0, ttce_pkg::LAST_COL};
                        end
                    end
                    ttce_pkg::KIND_CR: begin
                        ncol = '0;
                    end
                    ttce_pkg::KIND_LF: begin
                        nrow = {1'b0, row_reg} + 1'b1;
                    end
                    ttce_pkg::KIND_TAB, ttce_pkg::KIND_PUT: begin
                        ram_we    = 1'b1;
                        ram_waddr = {ttce_pkg::phys_row(row_reg, base_reg), col_reg};
                        ram_wdata = {bright_reg, sym_reg};
                        res_next.cell_written = 1'b1;
                        res_next.cell_row     = ttce_pkg::row_field_t'(row_reg);
                        res_next.cell_col     = ttce_pkg::col_field_t'(col_reg);
                        res_next.symbol       = sym_reg;
                        res_next.bright       = bright_reg;
                        ncol = {1'b0, col_reg} + 1'b1;
                    end
                    default: begin
                    end
                endcase

                // Wrap at the row end, scroll past the last row
                if (ncol == ttce_pkg::COLS_WIDE) begin
                    ncol = '0;
                    nrow = nrow + 1'b1;
                end
                if (nrow == ttce_pkg::ROWS_WIDE) begin
                    nrow              = {1'b0, ttce_pkg::LAST_ROW};
                    res_next.scrolled = 1'b1;
                    scroll_next       = 1'b1;
                    scrub_row_next    = base_reg;
                    base_next         = (base_reg == ttce_pkg::LAST_ROW) ? '0
                                                                         : base_reg + 1'b1;
                end

                if (is_write) begin
                    left_next = left_reg - 1'b1;
                end
                row_next            = nrow[ttce_pkg::ROW_W-1:0];
                col_next            = ncol[ttce_pkg::COL_W-1:0];
                res_next.cursor_row = ttce_pkg::row_field_t'(nrow[ttce_pkg::ROW_W-1:0]);
                res_next.cursor_col = ttce_pkg::col_field_t'(ncol[ttce_pkg::COL_W-1:0]);
                res_next.last       = is_write ? (left_reg == ttce_pkg::tab_cnt_t'(1)) : 1'b1;
                state_next          = S_EMIT;
            end

            S_EMIT: begin
                if (res_ready) begin
                    if (scroll_reg) begin
                        sweep_next = '0;
                        state_next = S_SCRUB;
                    end else if (left_reg != '0) begin
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_SCRUB: begin
                // Recycled row becomes the new bottom row: zero it
                ram_we     = 1'b1;
                ram_waddr  = {scrub_row_reg, sweep_reg[ttce_pkg::COL_W-1:0]};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[ttce_pkg::COL_W-1:0] == ttce_pkg::LAST_COL) begin
                    scroll_next = 1'b0;
                    state_next  = (left_reg != '0) ? S_EXEC : S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            row_reg    <= '0;
            col_reg    <= '0;
            base_reg   <= '0;
            sweep_reg  <= '0;
            scroll_reg <= 1'b0;
            left_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            base_reg   <= base_next;
            sweep_reg  <= sweep_next;
            scroll_reg <= scroll_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        scrub_row_reg <= scrub_row_next;
        kind_reg      <= kind_next;
        sym_reg       <= sym_next;
        bright_reg    <= bright_next;
        rd_row_reg    <= rd_row_next;
        rd_col_reg    <= rd_col_next;
        rd_ok_reg     <= rd_ok_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/text_terminal_cell_engine.sv =====
// Text terminal cell engine, top level.
// Plain byte or cell read: result via S_EXEC or S_READ, S_EMIT and the output register to m_*.
// Next input once back in S_IDLE. Tab: 8 results; a scroll adds an S_SCRUB sweep that zeroes a row.
// Rate is set by the single sequencer sharing the one-write, one-read cell RAM.
// After aresetn low, a clearing pass writes all 2^ROW_W x 2^COL_W RAM words
// with s_tready low; cursor, parser, attribute and row base reset to zero.
`default_nettype none

module text_terminal_cell_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // byte_in[7:0], read_row[11:8], read_col[16:12]
    input  wire logic        s_tuser,   // func (0 terminal byte, 1 cell read)
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // cell_row[3:0], cell_col[8:4], symbol[16:9],
                                        // bright[17], cursor_row[21:18],
                                        // cursor_col[26:22], scrolled[27]
    output logic             m_tuser,   // cell_written
    output logic             m_tlast    // last result of one input transfer
);

    ttce_pkg::byte_class_t cls;
    ttce_pkg::result_t     res;
    ttce_pkg::addr_t       ram_waddr, ram_raddr;
    ttce_pkg::cell_t       ram_wdata, ram_rdata;
    logic                  ram_we;
    logic                  step;
    logic                  res_valid;
    logic                  out_free;

    // Output register state
    logic              m_valid_reg, m_valid_next;
    ttce_pkg::result_t m_res_reg;

    // Escape parser and attribute
    ttce_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_in (s_tdata[7:0]),
        .step    (step),
        .cls     (cls)
    );

    // Sequencer: cursor, scroll by row rotation, clear sweeps
    ttce_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (s_tuser),
        .s_byte    (s_tdata[7:0]),
        .s_row     (s_tdata[11:8]),
        .s_col     (s_tdata[16:12]),
        .step      (step),
        .cls       (cls),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (out_free)
    );

    // Cell store: {bright, symbol}, addressed {physical row, column}
    ttce_ram #(
        .DATA_W (ttce_pkg::CELL_W),
        .ADDR_W (ttce_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: the sequencer hands over a result when this slot is
    // empty or drains in the same cycle, so it can work on the next result while one waits here.
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.cell_written;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {4'b0000,
                       m_res_reg.scrolled,
                       m_res_reg.cursor_col,
                       m_res_reg.cursor_row,
                       m_res_reg.bright,
                       m_res_reg.symbol,
                       m_res_reg.cell_col,
                       m_res_reg.cell_row};

endmodule

`default_nettype wire

// ===== rtl/core/ttce_checker.sv =====
// Port-level checks for the text terminal cell engine, bound to the top level.
// Depends on text_terminal_cell_engine_macros.svh.
`default_nettype none
`include "text_terminal_cell_engine_macros.svh"

module ttce_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `TTCE_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    `TTCE_ASSERT_CLK(a_one_item, s_tvalid && s_tready |=> !s_tready, "input taken back to back")

    `TTCE_ASSERT_CLK(a_run_busy, m_tvalid && !m_tlast |-> !s_tready, "input open mid run")

    `TTCE_ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

endmodule

bind text_terminal_cell_engine ttce_checker u_ttce_checker (.*);

`default_nettype wire
